// ===== hw/rtl/rgbl_pkg.sv =====
// Shared constants, tables and types for the RGB to CIE L*a*b* converter.
// Holds the linearization tables, which are built at elaboration time.
// No dependencies.
package rgbl_pkg;

   // channel and fixed-point formats
   localparam int CHANNEL_BITS  = 8;
   localparam int FRACTION_BITS = 4;
   localparam int QBITS         = 24;
   localparam int CODES         = 1 << CHANNEL_BITS;
   localparam longint unsigned CODE_MAX = 64'(CODES - 1);
   localparam longint unsigned QONE     = 64'd1 << QBITS;

   // Q24 values up to and including 1.0
   localparam int LIN_BITS  = QBITS + 1;
   localparam int COEF_BITS = 14;
   localparam int SUM_BITS  = LIN_BITS + COEF_BITS - 1;
   localparam int NUM_BITS  = SUM_BITS + 3;
   localparam int DEN_BITS  = 17;
   localparam int SQ_BITS   = 2 * LIN_BITS;
   localparam int PART_BITS = SQ_BITS - QBITS;

   // lane: three division stages, root bits, then two finishing stages
   localparam int LANE_DEPTH = 3 + LIN_BITS + 2;
   // three matrix stages in front, two output stages behind
   localparam int PIPE_DEPTH = LANE_DEPTH + 5;

   // RGB to XYZ matrix in units of 1e-4, rows X, Y, Z
   localparam logic [COEF_BITS-1:0] COEF [3][3] = '{
      '{COEF_BITS'(4124), COEF_BITS'(3576), COEF_BITS'(1805)},
      '{COEF_BITS'(2126), COEF_BITS'(7152), COEF_BITS'(722)},
      '{COEF_BITS'(193),  COEF_BITS'(1192), COEF_BITS'(9505)}
   };

   // white point divisors (X and Z numerators carry an extra factor 10)
   localparam longint unsigned X_DEN  = 98072;
   localparam longint unsigned Y_DEN  = 10000;
   localparam longint unsigned Z_DEN  = 118225;
   localparam longint unsigned X_HALF = X_DEN / 2;
   localparam longint unsigned Y_HALF = Y_DEN / 2;
   localparam longint unsigned Z_HALF = Z_DEN / 2;

   // white point division as a reciprocal multiply: q = (num * recip) >> WP_SHIFT,
   // exact for every numerator below 2^NUM_BITS since each divisor is below 2^DEN_BITS
   localparam int              WP_SHIFT      = NUM_BITS + DEN_BITS;
   localparam int              WP_RECIP_BITS = 45;
   localparam longint unsigned X_RECIP = ((64'd1 << WP_SHIFT) + X_DEN - 64'd1) / X_DEN;
   localparam longint unsigned Y_RECIP = ((64'd1 << WP_SHIFT) + Y_DEN - 64'd1) / Y_DEN;
   localparam longint unsigned Z_RECIP = ((64'd1 << WP_SHIFT) + Z_DEN - 64'd1) / Z_DEN;
   // operand split for the partial products
   localparam int              NUM_LO_BITS   = 21;
   localparam int              NUM_HI_BITS   = NUM_BITS - NUM_LO_BITS;
   localparam int              RCP_LO_BITS   = 23;
   localparam int              RCP_HI_BITS   = WP_RECIP_BITS - RCP_LO_BITS;

   // Lab function: cube root above the knee, straight line below
   localparam longint unsigned KNEE     = (64'd8856 * QONE) / 64'd1000000;
   localparam int              SEG_BITS = $clog2(KNEE + 1);
   localparam longint unsigned SLOPE    = 7787;
   localparam int              SEG_PROD_BITS = SEG_BITS + 13;
   // divide by 1000 as a shift by 3 and a reciprocal multiply for 125
   localparam int              SEG_X_BITS   = SEG_PROD_BITS - 3;
   localparam int              RECIP_SHIFT  = SEG_X_BITS + 7;
   localparam longint unsigned RECIP_125    = ((64'd1 << RECIP_SHIFT) + 64'd124) / 64'd125;
   localparam int              RECIP_BITS   = SEG_X_BITS + 1;
   localparam longint unsigned SEG_OFFSET   = (64'd4 * QONE + 64'd14) / 64'd29;

   // output fields
   localparam int L_BITS    = 11;
   localparam int AB_BITS   = 13;
   localparam int WIDE_BITS = 36;
   localparam int L_MIN     = 0;
   localparam int L_MAX     = 2047;
   localparam int AB_MIN    = -2560;
   localparam int AB_MAX    = 2559;

   typedef logic [LIN_BITS-1:0] lin_table_type [CODES];

   // sRGB curve denominators
   localparam longint unsigned PLAIN_DEN = CODE_MAX;
   localparam longint unsigned SEGL_DEN  = CODE_MAX * 64'd1292;
   localparam longint unsigned GAMMA_DEN = CODE_MAX * 64'd1055;

   // r^5 in Q24 by four truncating steps
   function automatic longint unsigned fifth_q(input longint unsigned r);
      longint unsigned p;
      p = r;
      for (int k = 0; k < 4; k++) begin
         p = (p * r) >> QBITS;
      end
      return p;
   endfunction

   // code to linear Q24 value, with or without the sRGB curve
   function automatic lin_table_type build_lin(input bit gamma);
      lin_table_type   tbl;
      longint unsigned c;
      longint unsigned t;
      longint unsigned s;
      longint unsigned r;
      longint unsigned cand;
      for (int i = 0; i < CODES; i++) begin
         c = 64'(i);
         if (!gamma) begin
            tbl[i] = LIN_BITS'(((c << QBITS) + PLAIN_DEN / 2) / PLAIN_DEN);
         end else if (c * 64'd100000 <= 64'd4045 * CODE_MAX) begin
            tbl[i] = LIN_BITS'(((c * (64'd100 << QBITS)) + SEGL_DEN / 2) / SEGL_DEN);
         end else begin
            t = ((((c * 64'd1000) + 64'd55 * CODE_MAX) << QBITS) + GAMMA_DEN / 2) / GAMMA_DEN;
            s = (t * t + (QONE >> 1)) >> QBITS;
            // largest fifth root not above s, one bit at a time
            r = 0;
            for (int k = QBITS; k >= 0; k--) begin
               cand = r | (64'd1 << k);
               if (cand <= QONE && fifth_q(cand) <= s) begin
                  r = cand;
               end
            end
            tbl[i] = LIN_BITS'((s * r + (QONE >> 1)) >> QBITS);
         end
      end
      return tbl;
   endfunction

   localparam lin_table_type LIN_GAMMA = build_lin(1'b1);
   localparam lin_table_type LIN_PLAIN = build_lin(1'b0);

endpackage

// ===== hw/rtl/rgb_to_cielab_unit.sv =====
// Top level of the RGB to CIE L*a*b* converter.
// Instantiates rgbl_matrix, three rgbl_lane and rgbl_out; uses rgbl_pkg.
//
// Usage:
//   Input channel req_ carries one pixel (red, green, blue codes) per item;
//   an item is taken on a clock edge with req_valid high and req_stall low.
//   Result channel rsp_ carries L*, a*, b* in units of 1/16, saturated.
//   csr_wr_en with csr_wr_data sets apply_gamma (1 = sRGB curve first);
//   write it only while no items are in flight.
// Pipeline: from acceptance to rsp_valid an item passes three matrix
//   stages, three white-point division stages, the cube root at one bit per
//   stage over 25 bits and four finishing stages.
// Throughput: one item per cycle, sustained while no result is held by rsp_stall.
// Reset (synchronous): empties the pipeline and sets apply_gamma to 1.
// Stall: while a result is held by rsp_stall the whole pipeline freezes
//   and req_stall is raised; nothing is dropped or repeated.
module rgb_to_cielab_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rgbl_pkg::CHANNEL_BITS-1:0]   req_red,
   input  logic [rgbl_pkg::CHANNEL_BITS-1:0]   req_green,
   input  logic [rgbl_pkg::CHANNEL_BITS-1:0]   req_blue,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rgbl_pkg::L_BITS-1:0]         rsp_lightness,
   output logic signed [rgbl_pkg::AB_BITS-1:0] rsp_green_red,
   output logic signed [rgbl_pkg::AB_BITS-1:0] rsp_blue_yellow,
   input  logic                                csr_wr_en,
   input  logic                                csr_wr_data
);

   logic                                gamma_ff;
   logic [rgbl_pkg::PIPE_DEPTH-1:0]     vld_ff;
   logic                                advance;
   logic [rgbl_pkg::NUM_BITS-1:0]       num_x;
   logic [rgbl_pkg::NUM_BITS-1:0]       num_y;
   logic [rgbl_pkg::NUM_BITS-1:0]       num_z;
   logic [rgbl_pkg::LIN_BITS-1:0]       fx;
   logic [rgbl_pkg::LIN_BITS-1:0]       fy;
   logic [rgbl_pkg::LIN_BITS-1:0]       fz;

   // the pipeline moves unless a finished item is being held
   assign advance   = !(vld_ff[rgbl_pkg::PIPE_DEPTH-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[rgbl_pkg::PIPE_DEPTH-1];

   // gamma mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= 1'b1;
      end else if (csr_wr_en) begin
         gamma_ff <= csr_wr_data;
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[rgbl_pkg::PIPE_DEPTH-2:0], req_valid};
      end
   end

   rgbl_matrix u_matrix (
      .clock       (clock),
      .advance     (advance),
      .apply_gamma (gamma_ff),
      .red         (req_red),
      .green       (req_green),
      .blue        (req_blue),
      .num_x       (num_x),
      .num_y       (num_y),
      .num_z       (num_z)
   );

   rgbl_lane u_lane_x (
      .clock    (clock),
      .advance  (advance),
      .num      (num_x),
      .recip    (rgbl_pkg::WP_RECIP_BITS'(rgbl_pkg::X_RECIP)),
      .func_out (fx)
   );

   rgbl_lane u_lane_y (
      .clock    (clock),
      .advance  (advance),
      .num      (num_y),
      .recip    (rgbl_pkg::WP_RECIP_BITS'(rgbl_pkg::Y_RECIP)),
      .func_out (fy)
   );

   rgbl_lane u_lane_z (
      .clock    (clock),
      .advance  (advance),
      .num      (num_z),
      .recip    (rgbl_pkg::WP_RECIP_BITS'(rgbl_pkg::Z_RECIP)),
      .func_out (fz)
   );

   rgbl_out u_out (
      .clock       (clock),
      .advance     (advance),
      .fx          (fx),
      .fy          (fy),
      .fz          (fz),
      .lightness   (rsp_lightness),
      .green_red   (rsp_green_red),
      .blue_yellow (rsp_blue_yellow)
   );

endmodule

// ===== hw/rtl/rgbl_matrix.sv =====
// Front end: table linearization and the RGB to XYZ matrix, three stages.
// Produces the rounded white-point division numerators. Uses rgbl_pkg.
module rgbl_matrix (
   input  logic                           clock,
   input  logic                           advance,
   input  logic                           apply_gamma,
   input  logic [rgbl_pkg::CHANNEL_BITS-1:0] red,
   input  logic [rgbl_pkg::CHANNEL_BITS-1:0] green,
   input  logic [rgbl_pkg::CHANNEL_BITS-1:0] blue,
   output logic [rgbl_pkg::NUM_BITS-1:0]  num_x,
   output logic [rgbl_pkg::NUM_BITS-1:0]  num_y,
   output logic [rgbl_pkg::NUM_BITS-1:0]  num_z
);

   logic [rgbl_pkg::CHANNEL_BITS-1:0] code [3];
   logic [rgbl_pkg::LIN_BITS-1:0]     lin_ff [3];
   logic [rgbl_pkg::SUM_BITS-1:0]     prod_ff [3][3];
   logic [rgbl_pkg::SUM_BITS-1:0]     sum [3];
   logic [rgbl_pkg::NUM_BITS-1:0]     num_x_ff;
   logic [rgbl_pkg::NUM_BITS-1:0]     num_y_ff;
   logic [rgbl_pkg::NUM_BITS-1:0]     num_z_ff;

   assign code[0] = red;
   assign code[1] = green;
   assign code[2] = blue;

   // stage 1: table lookup per channel
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 3; c++) begin
            lin_ff[c] <= apply_gamma ? rgbl_pkg::LIN_GAMMA[code[c]]
                                     : rgbl_pkg::LIN_PLAIN[code[c]];
         end
      end
   end

   // stage 2: matrix products
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int row = 0; row < 3; row++) begin
            for (int col = 0; col < 3; col++) begin
               prod_ff[row][col] <= rgbl_pkg::SUM_BITS'(
                  rgbl_pkg::SUM_BITS'(lin_ff[col]) *
                  rgbl_pkg::SUM_BITS'(rgbl_pkg::COEF[row][col]));
            end
         end
      end
   end

   // stage 3: row sums, scaled and offset for round-to-nearest division
   always_comb begin
      for (int row = 0; row < 3; row++) begin
         sum[row] = prod_ff[row][0] + prod_ff[row][1] + prod_ff[row][2];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_x_ff <= (rgbl_pkg::NUM_BITS'(sum[0]) << 3) + (rgbl_pkg::NUM_BITS'(sum[0]) << 1)
                     + rgbl_pkg::NUM_BITS'(rgbl_pkg::X_HALF);
         num_y_ff <= rgbl_pkg::NUM_BITS'(sum[1]) + rgbl_pkg::NUM_BITS'(rgbl_pkg::Y_HALF);
         num_z_ff <= (rgbl_pkg::NUM_BITS'(sum[2]) << 3) + (rgbl_pkg::NUM_BITS'(sum[2]) << 1)
                     + rgbl_pkg::NUM_BITS'(rgbl_pkg::Z_HALF);
      end
   end

   assign num_x = num_x_ff;
   assign num_y = num_y_ff;
   assign num_z = num_z_ff;

endmodule

// ===== hw/rtl/rgbl_lane.sv =====
// One color lane: white-point division by reciprocal multiply, then the Lab
// function (pipelined cube root search or linear segment). Uses rgbl_pkg.
module rgbl_lane (
   input  logic                               clock,
   input  logic                               advance,
   input  logic [rgbl_pkg::NUM_BITS-1:0]      num,
   input  logic [rgbl_pkg::WP_RECIP_BITS-1:0] recip,
   output logic [rgbl_pkg::LIN_BITS-1:0]      func_out
);

   localparam int HH_BITS  = rgbl_pkg::NUM_HI_BITS + rgbl_pkg::RCP_HI_BITS;
   localparam int HL_BITS  = rgbl_pkg::NUM_HI_BITS + rgbl_pkg::RCP_LO_BITS;
   localparam int LH_BITS  = rgbl_pkg::NUM_LO_BITS + rgbl_pkg::RCP_HI_BITS;
   localparam int LL_BITS  = rgbl_pkg::NUM_LO_BITS + rgbl_pkg::RCP_LO_BITS;
   localparam int TOT_BITS = rgbl_pkg::NUM_BITS + rgbl_pkg::WP_RECIP_BITS;

   logic [rgbl_pkg::NUM_HI_BITS-1:0] num_hi;
   logic [rgbl_pkg::NUM_LO_BITS-1:0] num_lo;
   logic [rgbl_pkg::RCP_HI_BITS-1:0] rcp_hi;
   logic [rgbl_pkg::RCP_LO_BITS-1:0] rcp_lo;
   logic [HH_BITS-1:0]               hh_ff;
   logic [HH_BITS-1:0]               hh_hold_ff;
   logic [HL_BITS-1:0]               hl_ff;
   logic [LH_BITS-1:0]               lh_ff;
   logic [LL_BITS-1:0]               ll_ff;
   logic [TOT_BITS-1:0]              low_ff;
   logic [TOT_BITS-1:0]              total;
   logic [rgbl_pkg::LIN_BITS-1:0]    quo_ff;

   logic [rgbl_pkg::LIN_BITS-1:0] t_ff   [rgbl_pkg::LIN_BITS];
   logic [rgbl_pkg::LIN_BITS-1:0] root_ff [rgbl_pkg::LIN_BITS];
   logic [rgbl_pkg::SQ_BITS-1:0]  sq_ff  [rgbl_pkg::LIN_BITS];

   logic                               above_ff;
   logic [rgbl_pkg::LIN_BITS-1:0]      cube_ff;
   logic [rgbl_pkg::SEG_PROD_BITS-1:0] seg_ff;
   logic [rgbl_pkg::LIN_BITS-1:0]      func_ff;
   logic [rgbl_pkg::LIN_BITS-1:0]      t_last;
   logic [rgbl_pkg::SEG_X_BITS-1:0]    seg_x;
   logic [rgbl_pkg::SEG_X_BITS+rgbl_pkg::RECIP_BITS-1:0] seg_q;

   genvar i;

   assign num_hi = num[rgbl_pkg::NUM_BITS-1:rgbl_pkg::NUM_LO_BITS];
   assign num_lo = num[rgbl_pkg::NUM_LO_BITS-1:0];
   assign rcp_hi = recip[rgbl_pkg::WP_RECIP_BITS-1:rgbl_pkg::RCP_LO_BITS];
   assign rcp_lo = recip[rgbl_pkg::RCP_LO_BITS-1:0];

   // division 1: four partial products of numerator and reciprocal
   always_ff @(posedge clock) begin
      if (advance) begin
         hh_ff <= HH_BITS'(num_hi) * HH_BITS'(rcp_hi);
         hl_ff <= HL_BITS'(num_hi) * HL_BITS'(rcp_lo);
         lh_ff <= LH_BITS'(num_lo) * LH_BITS'(rcp_hi);
         ll_ff <= LL_BITS'(num_lo) * LL_BITS'(rcp_lo);
      end
   end

   // division 2: sum the lower partial products
   always_ff @(posedge clock) begin
      if (advance) begin
         hh_hold_ff <= hh_ff;
         low_ff     <= TOT_BITS'(ll_ff)
                       + (TOT_BITS'(hl_ff) << rgbl_pkg::NUM_LO_BITS)
                       + (TOT_BITS'(lh_ff) << rgbl_pkg::RCP_LO_BITS);
      end
   end

   // division 3: add the top product, keep the quotient bits
   assign total = (TOT_BITS'(hh_hold_ff) << (rgbl_pkg::NUM_LO_BITS + rgbl_pkg::RCP_LO_BITS))
                  + low_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         quo_ff <= total[rgbl_pkg::WP_SHIFT+rgbl_pkg::LIN_BITS-1:rgbl_pkg::WP_SHIFT];
      end
   end

   // cube root search, one bit per stage; the exact square is kept by adds
   for (i = 0; i < rgbl_pkg::LIN_BITS; i++) begin : g_root
      logic [rgbl_pkg::LIN_BITS-1:0]  t_prev;
      logic [rgbl_pkg::LIN_BITS-1:0]  root_prev;
      logic [rgbl_pkg::SQ_BITS-1:0]   sq_prev;
      logic [rgbl_pkg::LIN_BITS-1:0]  cand;
      logic [rgbl_pkg::SQ_BITS-1:0]   cand_sq;
      logic [rgbl_pkg::PART_BITS-1:0] part;
      logic [rgbl_pkg::PART_BITS+rgbl_pkg::LIN_BITS-1:0] cube;
      logic                           fits;
      if (i == 0) begin : g_first
         assign t_prev    = quo_ff;
         assign root_prev = '0;
         assign sq_prev   = '0;
      end else begin : g_next
         assign t_prev    = t_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign sq_prev   = sq_ff[i-1];
      end
      assign cand    = root_prev | (rgbl_pkg::LIN_BITS'(1) << (rgbl_pkg::LIN_BITS - 1 - i));
      assign cand_sq = sq_prev
                       + (rgbl_pkg::SQ_BITS'(root_prev) << (rgbl_pkg::LIN_BITS - i))
                       + (rgbl_pkg::SQ_BITS'(1) << (2 * (rgbl_pkg::LIN_BITS - 1 - i)));
      assign part    = cand_sq[rgbl_pkg::SQ_BITS-1:rgbl_pkg::QBITS];
      assign cube    = (rgbl_pkg::PART_BITS+rgbl_pkg::LIN_BITS)'(part) *
                       (rgbl_pkg::PART_BITS+rgbl_pkg::LIN_BITS)'(cand);
      assign fits    = cube[rgbl_pkg::PART_BITS+rgbl_pkg::LIN_BITS-1:rgbl_pkg::QBITS]
                       <= (rgbl_pkg::PART_BITS+rgbl_pkg::LIN_BITS-rgbl_pkg::QBITS)'(t_prev);
      always_ff @(posedge clock) begin
         if (advance) begin
            t_ff[i]    <= t_prev;
            root_ff[i] <= fits ? cand : root_prev;
            sq_ff[i]   <= fits ? cand_sq : sq_prev;
         end
      end
   end

   assign t_last = t_ff[rgbl_pkg::LIN_BITS-1];

   // finish 1: pick the segment, start the linear-segment product
   always_ff @(posedge clock) begin
      if (advance) begin
         above_ff <= rgbl_pkg::LIN_BITS'(t_last) > rgbl_pkg::LIN_BITS'(rgbl_pkg::KNEE);
         cube_ff  <= root_ff[rgbl_pkg::LIN_BITS-1];
         seg_ff   <= rgbl_pkg::SEG_PROD_BITS'(rgbl_pkg::SLOPE) *
                     rgbl_pkg::SEG_PROD_BITS'(t_last[rgbl_pkg::SEG_BITS-1:0])
                     + rgbl_pkg::SEG_PROD_BITS'(500);
      end
   end

   // finish 2: divide by 1000 via shift and reciprocal, add the offset
   assign seg_x = seg_ff[rgbl_pkg::SEG_PROD_BITS-1:3];
   assign seg_q = (rgbl_pkg::SEG_X_BITS+rgbl_pkg::RECIP_BITS)'(seg_x) *
                  (rgbl_pkg::SEG_X_BITS+rgbl_pkg::RECIP_BITS)'(rgbl_pkg::RECIP_125);

   always_ff @(posedge clock) begin
      if (advance) begin
         func_ff <= above_ff ? cube_ff
                  : rgbl_pkg::LIN_BITS'(seg_q >> rgbl_pkg::RECIP_SHIFT)
                    + rgbl_pkg::LIN_BITS'(rgbl_pkg::SEG_OFFSET);
      end
   end

   assign func_out = func_ff;

endmodule

// ===== hw/rtl/rgbl_out.sv =====
// Back end: forms L*, a*, b* from the Lab function values, rounds to the
// output fraction and saturates; holds the result register. Uses rgbl_pkg.
module rgbl_out (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic [rgbl_pkg::LIN_BITS-1:0]         fx,
   input  logic [rgbl_pkg::LIN_BITS-1:0]         fy,
   input  logic [rgbl_pkg::LIN_BITS-1:0]         fz,
   output logic [rgbl_pkg::L_BITS-1:0]           lightness,
   output logic signed [rgbl_pkg::AB_BITS-1:0]   green_red,
   output logic signed [rgbl_pkg::AB_BITS-1:0]   blue_yellow
);

   localparam int SHIFT = rgbl_pkg::QBITS - rgbl_pkg::FRACTION_BITS;

   logic signed [rgbl_pkg::WIDE_BITS-1:0] sfx;
   logic signed [rgbl_pkg::WIDE_BITS-1:0] sfy;
   logic signed [rgbl_pkg::WIDE_BITS-1:0] sfz;
   logic signed [rgbl_pkg::WIDE_BITS-1:0] l_ff;
   logic signed [rgbl_pkg::WIDE_BITS-1:0] a_ff;
   logic signed [rgbl_pkg::WIDE_BITS-1:0] b_ff;
   logic signed [rgbl_pkg::WIDE_BITS-1:0] l_rnd;
   logic signed [rgbl_pkg::WIDE_BITS-1:0] a_rnd;
   logic signed [rgbl_pkg::WIDE_BITS-1:0] b_rnd;
   logic [rgbl_pkg::L_BITS-1:0]           light_ff;
   logic signed [rgbl_pkg::AB_BITS-1:0]   gr_ff;
   logic signed [rgbl_pkg::AB_BITS-1:0]   by_ff;

   // round half away from zero to the output fraction
   function automatic logic signed [rgbl_pkg::WIDE_BITS-1:0] round_q(
      input logic signed [rgbl_pkg::WIDE_BITS-1:0] v);
      logic [rgbl_pkg::WIDE_BITS-1:0] mag;
      mag = v[rgbl_pkg::WIDE_BITS-1] ? rgbl_pkg::WIDE_BITS'(-v) : rgbl_pkg::WIDE_BITS'(v);
      mag = (mag + (rgbl_pkg::WIDE_BITS'(1) << (SHIFT - 1))) >> SHIFT;
      return v[rgbl_pkg::WIDE_BITS-1] ? -$signed(mag) : $signed(mag);
   endfunction

   // clamp to a field range
   function automatic logic signed [rgbl_pkg::WIDE_BITS-1:0] clamp(
      input logic signed [rgbl_pkg::WIDE_BITS-1:0] v,
      input int lo,
      input int hi);
      logic signed [rgbl_pkg::WIDE_BITS-1:0] vlo;
      logic signed [rgbl_pkg::WIDE_BITS-1:0] vhi;
      vlo = rgbl_pkg::WIDE_BITS'(lo);
      vhi = rgbl_pkg::WIDE_BITS'(hi);
      if (v < vlo) begin
         return vlo;
      end else if (v > vhi) begin
         return vhi;
      end
      return v;
   endfunction

   assign sfx = $signed(rgbl_pkg::WIDE_BITS'(fx));
   assign sfy = $signed(rgbl_pkg::WIDE_BITS'(fy));
   assign sfz = $signed(rgbl_pkg::WIDE_BITS'(fz));

   // stage 1: constant scalings
   always_ff @(posedge clock) begin
      if (advance) begin
         l_ff <= sfy * rgbl_pkg::WIDE_BITS'(116)
                 - $signed(rgbl_pkg::WIDE_BITS'(rgbl_pkg::QONE << 4));
         a_ff <= (sfx - sfy) * rgbl_pkg::WIDE_BITS'(500);
         b_ff <= (sfy - sfz) * rgbl_pkg::WIDE_BITS'(200);
      end
   end

   // stage 2: round, saturate, result register
   assign l_rnd = clamp(round_q(l_ff), rgbl_pkg::L_MIN, rgbl_pkg::L_MAX);
   assign a_rnd = clamp(round_q(a_ff), rgbl_pkg::AB_MIN, rgbl_pkg::AB_MAX);
   assign b_rnd = clamp(round_q(b_ff), rgbl_pkg::AB_MIN, rgbl_pkg::AB_MAX);

   always_ff @(posedge clock) begin
      if (advance) begin
         light_ff <= l_rnd[rgbl_pkg::L_BITS-1:0];
         gr_ff    <= a_rnd[rgbl_pkg::AB_BITS-1:0];
         by_ff    <= b_rnd[rgbl_pkg::AB_BITS-1:0];
      end
   end

   assign lightness   = light_ff;
   assign green_red   = gr_ff;
   assign blue_yellow = by_ff;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for rgb_to_cielab_unit: drives pixels, predicts L*a*b* in
// fixed point and checks every result in order. Depends on the DUT only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [10:0] lightness;
      logic [12:0] green_red;
      logic [12:0] blue_yellow;
   } lab_type;

   localparam longint unsigned Q1 = 64'd1 << 24;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [7:0] req_red = 0, req_green = 0, req_blue = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [10:0] rsp_lightness;
   logic signed [12:0] rsp_green_red, rsp_blue_yellow;
   logic csr_wr_en = 0;
   logic csr_wr_data = 0;

   rgb_to_cielab_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_lightness(rsp_lightness), .rsp_green_red(rsp_green_red),
      .rsp_blue_yellow(rsp_blue_yellow),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   pixel_type pending_pixels[$];
   lab_type   expected_lab[$];
   bit     gamma_on = 1;
   int     errors = 0;
   int     checked = 0;
   int     idle_cycles = 0;
   int     long_hold = 0;   // cycles the receiver still holds off
   bit     sender_pause = 0;

   function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
      return (n + d / 2) / d;
   endfunction

   function automatic longint unsigned pow5(longint unsigned r);
      longint unsigned p;
      p = r;
      for (int k = 0; k < 4; k++) p = (p * r) >> 24;
      return p;
   endfunction

   function automatic longint unsigned to_linear(longint unsigned c, bit gam);
      longint unsigned t, s, lo, hi, mid;
      if (!gam) return rdiv(c << 24, 255);
      if (c * 100000 <= 4045 * 255) return rdiv(c * (64'd100 << 24), 255 * 1292);
      t = rdiv((c * 1000 + 55 * 255) << 24, 1055 * 255);
      s = (t * t + (Q1 >> 1)) >> 24;
      lo = 0; hi = Q1;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (pow5(mid) <= s) lo = mid; else hi = mid - 1;
      end
      return (s * lo + (Q1 >> 1)) >> 24;
   endfunction

   function automatic longint unsigned lab_curve(longint unsigned t);
      longint unsigned lo, hi, mid, p;
      if (t * 1000000 > 8856 * Q1) begin
         lo = 0; hi = Q1 << 1;
         while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            p = (mid * mid) >> 24;
            if (((p * mid) >> 24) <= t) lo = mid; else hi = mid - 1;
         end
         return lo;
      end
      return rdiv(7787 * t, 1000) + rdiv(4 * Q1, 29);
   endfunction

   // Q24 to 1/16 units, half away from zero, then clamp
   function automatic longint to_sixteenths(longint v, longint lo, longint hi);
      longint unsigned mag;
      longint r;
      mag = v < 0 ? -v : v;
      mag = (mag + (64'd1 << 19)) >> 20;
      r = v < 0 ? -longint'(mag) : longint'(mag);
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   function automatic lab_type convert_pixel(pixel_type px, bit gam);
      longint unsigned r, g, b, sx, sy, sz;
      longint fx, fy, fz;
      lab_type o;
      r = to_linear(px.red, gam);
      g = to_linear(px.green, gam);
      b = to_linear(px.blue, gam);
      sx = 4124 * r + 3576 * g + 1805 * b;
      sy = 2126 * r + 7152 * g + 722 * b;
      sz = 193 * r + 1192 * g + 9505 * b;
      fx = lab_curve(rdiv(sx * 10, 98072));
      fy = lab_curve(rdiv(sy, 10000));
      fz = lab_curve(rdiv(sz * 10, 118225));
      o.lightness   = 11'(to_sixteenths(116 * fy - 16 * longint'(Q1), 0, 2047));
      o.green_red   = 13'(to_sixteenths(500 * (fx - fy), -2560, 2559));
      o.blue_yellow = 13'(to_sixteenths(200 * (fy - fz), -2560, 2559));
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, checked);
   endtask

   // driver: one item at a time from the pending queue, random gaps
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && !req_stall) begin
         expected_lab.push_back(convert_pixel({req_red, req_green, req_blue}, gamma_on));
         send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
         if (send_gap == 0 && pending_pixels.size() > 0 && !sender_pause) begin
            {req_red, req_green, req_blue} <= pending_pixels.pop_front();
         end else begin
            req_valid <= 0;
         end
      end else if (!req_valid) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_pixels.size() > 0 && !sender_pause) begin
            {req_red, req_green, req_blue} <= pending_pixels.pop_front();
            req_valid <= 1;
         end
      end
   end

   // monitor: compare and draw the next stall
   int recv_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_lab.size() == 0) begin
               report_mismatch("unexpected result lightness", rsp_lightness, 0);
            end else begin
               lab_type w;
               w = expected_lab.pop_front();
               if (rsp_lightness !== w.lightness)
                  report_mismatch("lightness", rsp_lightness, w.lightness);
               if (rsp_green_red !== w.green_red)
                  report_mismatch("green_red", rsp_green_red, $signed(w.green_red));
               if (rsp_blue_yellow !== w.blue_yellow)
                  report_mismatch("blue_yellow", rsp_blue_yellow, $signed(w.blue_yellow));
            end
            checked++;
            recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_stall <= 1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired");
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_pixels.size() > 0 || req_valid || expected_lab.size() > 0)
         @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_gamma(bit v);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      gamma_on = v;
   endtask

   task automatic add_random(int n);
      pixel_type p;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: p = {3{8'($urandom_range(0, 255))}};            // grays
            1: p = {8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                    8'($urandom_range(0, 12))};                 // near black
            2: p = {8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
                    8'($urandom)};
            default: p = 24'($urandom);
         endcase
         pending_pixels.push_back(p);
      end
   endtask

   initial begin
      pixel_type corners[$];
      repeat (7) @(posedge clock);
      reset <= 0;

      // directed: primaries, black, white, gamma knee, single bits
      corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                  24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h0A0A0A, 24'h0B0B0B,
                  24'h010101, 24'h808080, 24'h7F7F7F, 24'h550A0B, 24'hFE0100};
      for (int ph = 0; ph < 2; ph++) begin
         write_gamma(ph == 0);
         foreach (corners[i]) pending_pixels.push_back(corners[i]);
         wait_drained();
      end

      // random phases, alternating gamma setting
      for (int ph = 0; ph < 6; ph++) begin
         write_gamma(ph % 2);
         add_random(300);
         if (ph == 2) begin
            // receiver holds off while the sender keeps offering
            repeat (20) @(posedge clock);
            long_hold = 200;
         end
         if (ph == 4) begin
            // sender pauses until everything has drained
            repeat (100) @(posedge clock);
            sender_pause = 1;
            while (req_valid || expected_lab.size() > 0) @(posedge clock);
            sender_pause = 0;
         end
         wait_drained();
      end

      $display("covered %0d results, gamma on and off, extremes and long stalls", checked);
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
